// ===== rtl/vxfc_pkg.sv =====
package vxfc_pkg;

  localparam int WORD_W   = 32;
  localparam int BIT_W    = 5;
  localparam int COL_W    = 3;
  localparam int COORD_W  = 8;
  localparam int NUM_MASK = 4;
  localparam int SEL_W    = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int WPR_W      = 4;
  localparam int RPL_W      = 9;
  localparam int LC_W       = 9;

  // compare widths wide enough for the parameter ranges
  localparam int WPR_CMP_W = 7;
  localparam int CNT_CMP_W = 11;

  localparam int DEF_MAX_WORD_COLUMNS = 8;
  localparam int DEF_MAX_ROWS         = 256;
  localparam int DEF_MAX_LAYERS       = 256;

  localparam logic [WPR_W-1:0] WPR_RESET = 4'd8;
  localparam logic [RPL_W-1:0] RPL_RESET = 9'd32;
  localparam logic [LC_W-1:0]  LC_RESET  = 9'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_WORDS_PER_ROW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_LAYER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT    = 2'd2;

  // mask slots, in emission order
  localparam logic [SEL_W-1:0] MSK_HELD_POS = 2'd0;
  localparam logic [SEL_W-1:0] MSK_HELD_NEG = 2'd1;
  localparam logic [SEL_W-1:0] MSK_NEW_POS  = 2'd2;
  localparam logic [SEL_W-1:0] MSK_NEW_NEG  = 2'd3;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic load;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic any;
    logic last;
  } status_t;

endpackage

// ===== rtl/vxfc_ctrl.sv =====
module vxfc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  vxfc_pkg::status_t status,
  output vxfc_pkg::cmd_t    cmd
);
  import vxfc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!status.any) state_nxt = ST_IDLE;
        else if (out_ready && status.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        out_valid = status.any;
        cmd.pop   = status.any && out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/vxfc_dp.sv =====
module vxfc_dp #(
  parameter int MAX_WORD_COLUMNS = vxfc_pkg::DEF_MAX_WORD_COLUMNS,
  parameter int MAX_ROWS         = vxfc_pkg::DEF_MAX_ROWS,
  parameter int MAX_LAYERS       = vxfc_pkg::DEF_MAX_LAYERS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  vxfc_pkg::cmd_t                        cmd,
  output vxfc_pkg::status_t                     status,
  input  logic [vxfc_pkg::WORD_W-1:0]           in_word,
  input  logic                                  cfg_we,
  input  logic [vxfc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vxfc_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic [vxfc_pkg::COORD_W-1:0]          voxel_x,
  output logic [vxfc_pkg::COORD_W-1:0]          voxel_y,
  output logic [vxfc_pkg::COORD_W-1:0]          voxel_z,
  output logic                                  face_side,
  output logic                                  last_face
);
  import vxfc_pkg::*;

  localparam logic [WPR_CMP_W-1:0] MAX_WPR = WPR_CMP_W'(MAX_WORD_COLUMNS);
  localparam logic [CNT_CMP_W-1:0] MAX_RPL = CNT_CMP_W'(MAX_ROWS);
  localparam logic [CNT_CMP_W-1:0] MAX_LC  = CNT_CMP_W'(MAX_LAYERS);

  logic [WPR_W-1:0]   wpr_r, wpr_nxt;
  logic [RPL_W-1:0]   rpl_r, rpl_nxt;
  logic [LC_W-1:0]    lc_r, lc_nxt;
  logic [WORD_W-1:0]  held_r, held_nxt;
  logic [WORD_W-1:0]  left_r, left_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [COORD_W-1:0] layer_r, layer_nxt;
  logic [COL_W-1:0]   held_col_r, held_col_nxt;
  logic [COL_W-1:0]   new_col_r, new_col_nxt;
  logic [COORD_W-1:0] emit_row_r, emit_row_nxt;
  logic [COORD_W-1:0] emit_layer_r, emit_layer_nxt;
  logic [NUM_MASK-1:0][WORD_W-1:0] mask_r, mask_nxt;

  logic [WPR_CMP_W-1:0] wpr_c;
  logic [CNT_CMP_W-1:0] rpl_c, lc_c;
  logic                 closes;
  logic [SEL_W-1:0]     sel;
  logic [WORD_W-1:0]    cur, iso, popped;
  logic [NUM_MASK-1:0][WORD_W-1:0] rem;
  logic [BIT_W-1:0]     bit_idx;

  always_comb begin
    if (wpr_r == '0) wpr_c = WPR_CMP_W'(1);
    else if (WPR_CMP_W'(wpr_r) > MAX_WPR) wpr_c = MAX_WPR;
    else wpr_c = WPR_CMP_W'(wpr_r);
    if (rpl_r == '0) rpl_c = CNT_CMP_W'(1);
    else if (CNT_CMP_W'(rpl_r) > MAX_RPL) rpl_c = MAX_RPL;
    else rpl_c = CNT_CMP_W'(rpl_r);
    if (lc_r == '0) lc_c = CNT_CMP_W'(1);
    else if (CNT_CMP_W'(lc_r) > MAX_LC) lc_c = MAX_LC;
    else lc_c = CNT_CMP_W'(lc_r);
  end

  assign closes = (WPR_CMP_W'(col_r) + WPR_CMP_W'(1)) >= wpr_c;

  // first nonempty mask, lowest set bit of it
  always_comb begin
    if (mask_r[MSK_HELD_POS] != '0) sel = MSK_HELD_POS;
    else if (mask_r[MSK_HELD_NEG] != '0) sel = MSK_HELD_NEG;
    else if (mask_r[MSK_NEW_POS] != '0) sel = MSK_NEW_POS;
    else sel = MSK_NEW_NEG;
    cur    = mask_r[sel];
    iso    = cur & (~cur + WORD_W'(1));
    popped = cur & (cur - WORD_W'(1));
    bit_idx = '0;
    for (int k = 0; k < WORD_W; k++) begin
      if (iso[k]) bit_idx = bit_idx | BIT_W'(k);
    end
    rem      = mask_r;
    rem[sel] = popped;
  end

  assign status.any  = |mask_r;
  assign status.last = ~|rem;

  assign voxel_x   = (sel == MSK_HELD_POS || sel == MSK_HELD_NEG) ?
                     {held_col_r, ~bit_idx} : {new_col_r, ~bit_idx};
  assign voxel_y   = emit_row_r;
  assign voxel_z   = emit_layer_r;
  assign face_side = (sel == MSK_HELD_NEG || sel == MSK_NEW_NEG);
  assign last_face = ~|rem;

  always_comb begin
    wpr_nxt        = wpr_r;
    rpl_nxt        = rpl_r;
    lc_nxt         = lc_r;
    held_nxt       = held_r;
    left_nxt       = left_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    layer_nxt      = layer_r;
    held_col_nxt   = held_col_r;
    new_col_nxt    = new_col_r;
    emit_row_nxt   = emit_row_r;
    emit_layer_nxt = emit_layer_r;
    mask_nxt       = mask_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_WORDS_PER_ROW:  wpr_nxt = cfg_data[WPR_W-1:0];
        CFG_ROWS_PER_LAYER: rpl_nxt = cfg_data[RPL_W-1:0];
        CFG_LAYER_COUNT:    lc_nxt  = cfg_data[LC_W-1:0];
        default:            wpr_nxt = wpr_r;
      endcase
    end

    if (cmd.pop) mask_nxt = rem;

    if (cmd.load) begin
      // held word is zero when nothing is held, so its masks come out empty
      mask_nxt[MSK_HELD_POS] = held_r & ~((held_r << 1) | {31'b0, in_word[31]});
      mask_nxt[MSK_HELD_NEG] = held_r & ~((held_r >> 1) | {left_r[0], 31'b0});
      mask_nxt[MSK_NEW_POS]  = '0;
      mask_nxt[MSK_NEW_NEG]  = '0;
      held_col_nxt   = col_r - COL_W'(1);
      new_col_nxt    = col_r;
      emit_row_nxt   = row_r;
      emit_layer_nxt = layer_r;
      if (closes) begin
        mask_nxt[MSK_NEW_POS] = in_word & ~(in_word << 1);
        mask_nxt[MSK_NEW_NEG] = in_word & ~((in_word >> 1) | {held_r[0], 31'b0});
        held_nxt = '0;
        left_nxt = '0;
        col_nxt  = '0;
        if ((CNT_CMP_W'(row_r) + CNT_CMP_W'(1)) >= rpl_c) begin
          row_nxt = '0;
          if ((CNT_CMP_W'(layer_r) + CNT_CMP_W'(1)) >= lc_c) layer_nxt = '0;
          else layer_nxt = layer_r + COORD_W'(1);
        end else begin
          row_nxt = row_r + COORD_W'(1);
        end
      end else begin
        held_nxt = in_word;
        left_nxt = held_r;
        col_nxt  = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpr_r   <= WPR_RESET;
      rpl_r   <= RPL_RESET;
      lc_r    <= LC_RESET;
      held_r  <= '0;
      left_r  <= '0;
      col_r   <= '0;
      row_r   <= '0;
      layer_r <= '0;
      mask_r  <= '0;
    end else begin
      wpr_r   <= wpr_nxt;
      rpl_r   <= rpl_nxt;
      lc_r    <= lc_nxt;
      held_r  <= held_nxt;
      left_r  <= left_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      layer_r <= layer_nxt;
      mask_r  <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_col_r   <= held_col_nxt;
    new_col_r    <= new_col_nxt;
    emit_row_r   <= emit_row_nxt;
    emit_layer_r <= emit_layer_nxt;
  end

endmodule

// ===== rtl/voxel_x_face_culler.sv =====
// Exposed +x / -x face extraction for a chunk of voxel occupancy words.
// Input channel (in_valid/in_ready): one 32-bit occupancy word per request,
// raster order x word, then row, then layer; bit 31 is the lowest x.
// A word is held until its +x neighbor arrives or it closes its row.
// Output channel (out_valid/out_ready): one face per request with voxel
// x/y/z, side (0 = +x, 1 = -x) and last_face on the final face of an input.
// Config port (cfg_we/cfg_index/cfg_data): words_per_row, rows_per_layer,
// layer_count; write only while idle.
// The first face is valid in the cycle after the input request is taken.
// One input yields N faces (0..64); one with no face still passes through
// the scan state. One face leaves per cycle while out_ready is high, from the
// lowest-set-bit scan over the four face masks.
// in_ready is low from the accepting edge until the edge that takes the
// last face.
// A stalled receiver freezes the scan; the face on the outputs holds.
// Reset: synchronous, active low; registers return to 8/32/32, the stream
// position to column, row and layer zero, with nothing held.
module voxel_x_face_culler #(
  parameter int MAX_WORD_COLUMNS = vxfc_pkg::DEF_MAX_WORD_COLUMNS,
  parameter int MAX_ROWS         = vxfc_pkg::DEF_MAX_ROWS,
  parameter int MAX_LAYERS       = vxfc_pkg::DEF_MAX_LAYERS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [vxfc_pkg::WORD_W-1:0]        in_occupancy_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [vxfc_pkg::COORD_W-1:0]       out_voxel_x,
  output logic [vxfc_pkg::COORD_W-1:0]       out_voxel_y,
  output logic [vxfc_pkg::COORD_W-1:0]       out_voxel_z,
  output logic                               out_face_side,
  output logic                               out_last_face,
  input  logic                               cfg_we,
  input  logic [vxfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vxfc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import vxfc_pkg::*;

  cmd_t    cmd;
  status_t status;

  vxfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  vxfc_dp #(
    .MAX_WORD_COLUMNS (MAX_WORD_COLUMNS),
    .MAX_ROWS         (MAX_ROWS),
    .MAX_LAYERS       (MAX_LAYERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_word   (in_occupancy_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .voxel_x   (out_voxel_x),
    .voxel_y   (out_voxel_y),
    .voxel_z   (out_voxel_z),
    .face_side (out_face_side),
    .last_face (out_last_face)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while faces pending");

  a_more_after_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_face) |=> out_valid)
    else $error("face stream ended without last marker");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second input accepted back to back");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_face) |=> (in_ready && !out_valid))
    else $error("block not idle after last face");

endmodule

// ===== verif/voxel_x_face_culler_test.sv =====
`timescale 1ns / 100ps

module voxel_x_face_culler_test;
  import vxfc_pkg::*;

  localparam int QUIET_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_REPORTS     = 10;
  localparam int IDLE_PCT        = 28;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic SIDE_POS = 1'b0;
  localparam logic SIDE_NEG = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] voxel_x;
    logic [COORD_W-1:0] voxel_y;
    logic [COORD_W-1:0] voxel_z;
    logic               face_side;
    logic               last_face;
  } face_t;

  class face_scoreboard;
    logic [WPR_W-1:0]   words_per_row;
    logic [RPL_W-1:0]   rows_per_layer;
    logic [LC_W-1:0]    layer_count;
    logic [WORD_W-1:0]  held_word;
    logic [WORD_W-1:0]  left_word;
    logic               holding;
    logic [COL_W-1:0]   column;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] layer;
    face_t              word_faces[$];
    face_t              faces_due[$];
    int                 mismatches;

    function new();
      words_per_row  = WPR_RESET;
      rows_per_layer = RPL_RESET;
      layer_count    = LC_RESET;
      held_word      = '0;
      left_word      = '0;
      holding        = 1'b0;
      column         = '0;
      row            = '0;
      layer          = '0;
      mismatches     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WORDS_PER_ROW:  words_per_row  = data[WPR_W-1:0];
        CFG_ROWS_PER_LAYER: rows_per_layer = data[RPL_W-1:0];
        CFG_LAYER_COUNT:    layer_count    = data[LC_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned effective(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    // lowest set bit first
    function void add_faces(logic [WORD_W-1:0] mask, logic side, logic [COL_W-1:0] col);
      face_t f;
      for (int b = 0; b < WORD_W; b++) begin
        if (mask[b]) begin
          f.voxel_x   = COORD_W'(col * 32 + 31 - b);
          f.voxel_y   = row;
          f.voxel_z   = layer;
          f.face_side = side;
          f.last_face = 1'b0;
          word_faces.insert(word_faces.size(), f);
        end
      end
    endfunction

    function void add_word(logic [WORD_W-1:0] w, logic [WORD_W-1:0] left,
                           logic [WORD_W-1:0] right, logic [COL_W-1:0] col);
      logic [WORD_W-1:0] pos_mask;
      logic [WORD_W-1:0] neg_mask;
      pos_mask = w & ~((w << 1) | {{(WORD_W-1){1'b0}}, right[WORD_W-1]});
      neg_mask = w & ~((w >> 1) | {left[0], {(WORD_W-1){1'b0}}});
      add_faces(pos_mask, SIDE_POS, col);
      add_faces(neg_mask, SIDE_NEG, col);
    endfunction

    function void note_request(logic [WORD_W-1:0] w);
      int unsigned       wpr;
      int unsigned       rpl;
      int unsigned       lc;
      logic [WORD_W-1:0] left_new;
      face_t             f;
      wpr = effective(int'(words_per_row), DEF_MAX_WORD_COLUMNS);
      rpl = effective(int'(rows_per_layer), DEF_MAX_ROWS);
      lc  = effective(int'(layer_count), DEF_MAX_LAYERS);
      left_new = '0;
      word_faces.delete();
      if (holding) begin
        add_word(held_word, left_word, w, column - 1'b1);
        left_new = held_word;
      end
      if (int'(column) + 1 >= wpr) begin
        add_word(w, left_new, '0, column);
        holding   = 1'b0;
        held_word = '0;
        left_word = '0;
        column    = '0;
        if (int'(row) + 1 >= rpl) begin
          row = '0;
          if (int'(layer) + 1 >= lc) layer = '0;
          else layer = layer + 1'b1;
        end else begin
          row = row + 1'b1;
        end
      end else begin
        held_word = w;
        left_word = left_new;
        holding   = 1'b1;
        column    = column + 1'b1;
      end
      foreach (word_faces[i]) begin
        f = word_faces[i];
        f.last_face = (i == word_faces.size() - 1);
        faces_due.insert(faces_due.size(), f);
      end
    endfunction

    function void check_face(face_t got);
      face_t want;
      if (faces_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected face: x=%0d y=%0d z=%0d side=%0d last=%0d",
                   got.voxel_x, got.voxel_y, got.voxel_z, got.face_side, got.last_face);
        return;
      end
      want = faces_due.pop_front();
      if (got.voxel_x !== want.voxel_x || got.voxel_y !== want.voxel_y ||
          got.voxel_z !== want.voxel_z || got.face_side !== want.face_side ||
          got.last_face !== want.last_face) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("face mismatch: expected x=%0d y=%0d z=%0d side=%0d last=%0d,",
                   want.voxel_x, want.voxel_y, want.voxel_z, want.face_side,
                   want.last_face,
                   " got x=%0d y=%0d z=%0d side=%0d last=%0d",
                   got.voxel_x, got.voxel_y, got.voxel_z, got.face_side, got.last_face);
      end
    endfunction

    function bit busy();
      return faces_due.size() != 0;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [WORD_W-1:0]     in_occupancy_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COORD_W-1:0]    out_voxel_x;
  logic [COORD_W-1:0]    out_voxel_y;
  logic [COORD_W-1:0]    out_voxel_z;
  logic                  out_face_side;
  logic                  out_last_face;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit steady = 1'b0;
  bit hold_off_request = 1'b0;
  int quiet_cycles = 0;

  face_scoreboard faces_sb = new();

  logic [WORD_W-1:0] directed_words [13] = '{
    32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h80000000,
    32'h00000001, 32'h80000000, 32'hAAAAAAAA, 32'h55555555,
    32'h0F0F0F0F, 32'hF0F0F0F0, 32'h12345678, 32'hDEADBEEF,
    32'h7FFFFFFE
  };

  voxel_x_face_culler u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_occupancy_word (in_occupancy_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_voxel_x       (out_voxel_x),
    .out_voxel_y       (out_voxel_y),
    .out_voxel_z       (out_voxel_z),
    .out_face_side     (out_face_side),
    .out_last_face     (out_last_face),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) faces_sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) faces_sb.note_request(in_occupancy_word);
      if (out_valid && out_ready)
        faces_sb.check_face(face_t'({out_voxel_x, out_voxel_y, out_voxel_z,
                                     out_face_side, out_last_face}));
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      @(posedge clk);
    end
  end

  function automatic logic [WORD_W-1:0] random_word();
    int unsigned k;
    int unsigned len;
    k   = $urandom_range(WORD_W - 1);
    len = $urandom_range(WORD_W, 1);
    case ($urandom_range(7))
      0: return $urandom;
      1: return '1;
      2: return '0;
      3: return WORD_W'(1) << k;
      4: return WORD_W'(((64'd1 << len) - 64'd1) << k);
      5: return $urandom & $urandom;
      6: return ~(WORD_W'(1) << k);
      default: return $urandom | $urandom;
    endcase
  endfunction

  task automatic send_word(logic [WORD_W-1:0] w);
    in_valid <= 1'b1;
    in_occupancy_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
  endtask

  // wait for every face, then let a word with no faces finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (faces_sb.busy()) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] wpr, logic [CFG_DATA_W-1:0] rpl,
                          logic [CFG_DATA_W-1:0] lc);
    settle();
    cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_write(CFG_WORDS_PER_ROW, wpr);
    cfg_write(CFG_ROWS_PER_LAYER, rpl);
    cfg_write(CFG_LAYER_COUNT, lc);
    cfg_we <= 1'b0;
  endtask

  task automatic run_words(int count);
    for (int i = 0; i < count; i++) send_word(random_word());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config; ends mid-row so the next width change lands on a held word
    foreach (directed_words[i]) send_word(directed_words[i]);

    set_regs(9'd1, 9'd1, 9'd1);
    run_words(20);
    set_regs(9'd0, 9'd0, 9'd0);
    run_words(20);

    set_regs(9'd15, 9'd511, 9'd511);
    steady = 1'b1;
    run_words(40);
    steady = 1'b0;

    set_regs(9'd3, 9'd2, 9'd3);
    run_words(40);

    // one word per row: walks every row and rolls into the next layer
    set_regs(9'd1, 9'd128, 9'd256);
    run_words(140);

    set_regs(9'd8, 9'd256, 9'd256);
    hold_off_request = 1'b1;
    run_words(40);

    repeat (2) begin
      set_regs(CFG_DATA_W'($urandom_range(15)), CFG_DATA_W'($urandom_range(511)),
               CFG_DATA_W'($urandom_range(511)));
      run_words(25);
    end

    settle();
    repeat (10) @(posedge clk);
    if (faces_sb.mismatches == 0 && !faces_sb.busy()) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
